// File: sv/one_vs_rest_confusion_metrics_top_defines.svh
// Assertion macros shared by the confusion metrics RTL.
`ifndef ONE_VS_REST_CONFUSION_METRICS_TOP_DEFINES_SVH
`define ONE_VS_REST_CONFUSION_METRICS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define OVRCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define OVRCM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define OVRCM_ASSERT_IMP(label, clk, rst, ante, cons)
`define OVRCM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/ovrcm_pkg.sv
// Types, constants and microcode ROM for the confusion metrics block.
`default_nettype none

package ovrcm_pkg;

   // Field widths of the stream payloads
   localparam int CLASS_FIELD_BITS = 8;
   localparam int COUNT_FIELD_BITS = 16;
   localparam int FRAC_BITS        = 16;
   localparam int RATIO_BITS       = FRAC_BITS + 1;
   localparam int REQ_DATA_BITS    = 2 * CLASS_FIELD_BITS;
   localparam int RSP_FIELD_BITS   = 4 * COUNT_FIELD_BITS + 5 * RATIO_BITS;
   localparam int RSP_DATA_BITS    = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS     = RSP_DATA_BITS - RSP_FIELD_BITS;

   // 1.0 in Q1.16
   localparam logic [RATIO_BITS-1:0] ONE_FIXED = RATIO_BITS'(1) << FRAC_BITS;

   // Restoring divider: one quotient bit per step
   localparam int DIV_STEPS = RATIO_BITS;
   localparam int ITER_BITS = $clog2(DIV_STEPS + 1);

   // Program counter
   localparam int ADDR_BITS = 5;
   typedef logic [ADDR_BITS-1:0] addr_type;

   localparam addr_type A_IDLE       = 5'd0;
   localparam addr_type A_TPR_LOAD   = 5'd1;
   localparam addr_type A_TPR_DIV    = 5'd2;
   localparam addr_type A_TPR_STORE  = 5'd3;
   localparam addr_type A_FPR_LOAD   = 5'd4;
   localparam addr_type A_FPR_DIV    = 5'd5;
   localparam addr_type A_FPR_STORE  = 5'd6;
   localparam addr_type A_PREC_LOAD  = 5'd7;
   localparam addr_type A_PREC_DIV   = 5'd8;
   localparam addr_type A_PREC_STORE = 5'd9;
   localparam addr_type A_ACC_LOAD   = 5'd10;
   localparam addr_type A_ACC_DIV    = 5'd11;
   localparam addr_type A_ACC_STORE  = 5'd12;
   localparam addr_type A_SPEC_LOAD  = 5'd13;
   localparam addr_type A_SPEC_DIV   = 5'd14;
   localparam addr_type A_SPEC_STORE = 5'd15;
   localparam addr_type A_EMIT       = 5'd16;

   // Datapath operation of one step
   typedef enum logic [2:0] {
      OP_WAIT_REQ,
      OP_LOAD,
      OP_DIV,
      OP_STORE,
      OP_EMIT
   } op_type;

   // Condition under which the step jumps to its target (else it holds)
   typedef enum logic [1:0] {
      CND_ALWAYS,
      CND_LAST,
      CND_DIV_DONE,
      CND_OUT_FREE
   } cond_type;

   // Ratio being worked on
   typedef enum logic [2:0] {
      R_TPR,
      R_FPR,
      R_PREC,
      R_ACC,
      R_SPEC
   } ratio_type;

   localparam int NUM_RATIOS = 5;

   typedef struct packed {
      op_type    op;
      ratio_type sel;
      cond_type  cnd;
      addr_type  target;
   } ucode_type;

   // Microcode ROM
   function automatic ucode_type ucode_rom(input addr_type addr);
      ucode_type w;
      w = '{op: OP_WAIT_REQ, sel: R_TPR, cnd: CND_LAST, target: A_TPR_LOAD};
      unique case (addr)
         A_IDLE:       w = '{OP_WAIT_REQ, R_TPR,  CND_LAST,     A_TPR_LOAD};
         A_TPR_LOAD:   w = '{OP_LOAD,     R_TPR,  CND_ALWAYS,   A_TPR_DIV};
         A_TPR_DIV:    w = '{OP_DIV,      R_TPR,  CND_DIV_DONE, A_TPR_STORE};
         A_TPR_STORE:  w = '{OP_STORE,    R_TPR,  CND_ALWAYS,   A_FPR_LOAD};
         A_FPR_LOAD:   w = '{OP_LOAD,     R_FPR,  CND_ALWAYS,   A_FPR_DIV};
         A_FPR_DIV:    w = '{OP_DIV,      R_FPR,  CND_DIV_DONE, A_FPR_STORE};
         A_FPR_STORE:  w = '{OP_STORE,    R_FPR,  CND_ALWAYS,   A_PREC_LOAD};
         A_PREC_LOAD:  w = '{OP_LOAD,     R_PREC, CND_ALWAYS,   A_PREC_DIV};
         A_PREC_DIV:   w = '{OP_DIV,      R_PREC, CND_DIV_DONE, A_PREC_STORE};
         A_PREC_STORE: w = '{OP_STORE,    R_PREC, CND_ALWAYS,   A_ACC_LOAD};
         A_ACC_LOAD:   w = '{OP_LOAD,     R_ACC,  CND_ALWAYS,   A_ACC_DIV};
         A_ACC_DIV:    w = '{OP_DIV,      R_ACC,  CND_DIV_DONE, A_ACC_STORE};
         A_ACC_STORE:  w = '{OP_STORE,    R_ACC,  CND_ALWAYS,   A_SPEC_LOAD};
         A_SPEC_LOAD:  w = '{OP_LOAD,     R_SPEC, CND_ALWAYS,   A_SPEC_DIV};
         A_SPEC_DIV:   w = '{OP_DIV,      R_SPEC, CND_DIV_DONE, A_SPEC_STORE};
         A_SPEC_STORE: w = '{OP_STORE,    R_SPEC, CND_ALWAYS,   A_EMIT};
         A_EMIT:       w = '{OP_EMIT,     R_TPR,  CND_OUT_FREE, A_IDLE};
         default:      w = '{OP_WAIT_REQ, R_TPR,  CND_ALWAYS,   A_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: sv/one_vs_rest_confusion_metrics_top.sv
// One-versus-rest confusion counters with a microcoded ratio divider.
// Requests without tlast are taken one per cycle and only bump a counter.
// A tlast request stalls the input for five ratios of 19 steps each
// (load, 17 restoring-divide steps, store) plus one emit step, which waits until the
// response slot is free; rsp_tvalid rises at the edge that ends emit.
// Synchronous reset: counters clear, target class is 1, no response pending.
`default_nettype none

`include "one_vs_rest_confusion_metrics_top_defines.svh"

module one_vs_rest_confusion_metrics_top #(
   parameter int COUNT_BITS = 16,
   parameter int CLASS_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_we,
   input  wire logic [ovrcm_pkg::CLASS_FIELD_BITS-1:0] csr_wdata,   // target_class
   // request stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ovrcm_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // true_class, predicted_class
   input  wire logic                                 req_tlast,   // last_sample
   // response stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // true_pos, false_pos, true_neg, false_neg, tp_rate, fp_rate,
   // precision_ratio, accuracy_ratio, specificity_ratio, zero pad
   output logic [ovrcm_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   localparam int DW       = COUNT_BITS + 2;
   localparam int CMP_BITS = (CLASS_BITS < ovrcm_pkg::CLASS_FIELD_BITS) ?
                             CLASS_BITS : ovrcm_pkg::CLASS_FIELD_BITS;
   localparam int CF       = ovrcm_pkg::CLASS_FIELD_BITS;
   localparam int RB       = ovrcm_pkg::RATIO_BITS;

   // Control state
   ovrcm_pkg::addr_type  pc_ff, pc_in;
   ovrcm_pkg::ucode_type ctl;
   logic [CF-1:0]         target_ff, target_in;
   logic [COUNT_BITS-1:0] count_tp_ff, count_tp_in;
   logic [COUNT_BITS-1:0] count_fp_ff, count_fp_in;
   logic [COUNT_BITS-1:0] count_tn_ff, count_tn_in;
   logic [COUNT_BITS-1:0] count_fn_ff, count_fn_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;

   // Divider datapath
   logic [DW-1:0]                     rem_ff, rem_in;
   logic [DW-1:0]                     den_ff, den_in;
   logic [RB-1:0]                     quot_ff, quot_in;
   logic [ovrcm_pkg::ITER_BITS-1:0]   iter_ff, iter_in;
   logic                              dz_ff, dz_in;
   logic [RB-1:0]                     ratio_ff [ovrcm_pkg::NUM_RATIOS];
   logic [RB-1:0]                     ratio_in [ovrcm_pkg::NUM_RATIOS];
   logic [ovrcm_pkg::RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Combinational helpers
   logic          req_acc, hit, is_target, out_free, emit_go, advance;
   logic [DW-1:0] tp_x, fp_x, tn_x, fn_x, num_sel, den_sel;
   logic [DW:0]   trial, diff;
   logic          ge;
   logic [RB-1:0] dflt;

   assign ctl        = ovrcm_pkg::ucode_rom(pc_ff);
   assign req_tready = (ctl.op == ovrcm_pkg::OP_WAIT_REQ);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign emit_go    = (ctl.op == ovrcm_pkg::OP_EMIT) && out_free;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Outcome of the incoming sample
   assign hit       = req_tdata[CMP_BITS-1:0] == req_tdata[CF+CMP_BITS-1:CF];
   assign is_target = req_tdata[CMP_BITS-1:0] == target_ff[CMP_BITS-1:0];

   // Widened counts for sums
   assign tp_x = DW'(count_tp_ff);
   assign fp_x = DW'(count_fp_ff);
   assign tn_x = DW'(count_tn_ff);
   assign fn_x = DW'(count_fn_ff);

   // Operand selection for the ratio in hand
   always_comb begin
      num_sel = tp_x;
      den_sel = tp_x + fn_x;
      dflt    = '0;
      unique case (ctl.sel)
         ovrcm_pkg::R_TPR: begin
            num_sel = tp_x;
            den_sel = tp_x + fn_x;
         end
         ovrcm_pkg::R_FPR: begin
            num_sel = fp_x;
            den_sel = fp_x + tn_x;
            dflt    = ovrcm_pkg::ONE_FIXED;
         end
         ovrcm_pkg::R_PREC: begin
            num_sel = tp_x;
            den_sel = tp_x + fp_x;
         end
         ovrcm_pkg::R_ACC: begin
            num_sel = tp_x + tn_x;
            den_sel = (tp_x + fp_x) + (tn_x + fn_x);
         end
         ovrcm_pkg::R_SPEC: begin
            num_sel = tn_x;
            den_sel = fp_x + tn_x;
         end
         default: begin
            num_sel = tp_x;
            den_sel = tp_x + fn_x;
         end
      endcase
   end

   // Restoring divide step; the first step takes the integer bit unshifted
   assign trial = (iter_ff == ovrcm_pkg::ITER_BITS'(ovrcm_pkg::DIV_STEPS)) ?
                  {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   // Sequencer jump condition
   always_comb begin
      unique case (ctl.cnd)
         ovrcm_pkg::CND_ALWAYS:   advance = 1'b1;
         ovrcm_pkg::CND_LAST:     advance = req_acc && req_tlast;
         ovrcm_pkg::CND_DIV_DONE: advance = iter_ff == ovrcm_pkg::ITER_BITS'(1);
         ovrcm_pkg::CND_OUT_FREE: advance = out_free;
         default:                 advance = 1'b0;
      endcase
   end

   // Next-state logic
   always_comb begin
      pc_in         = advance ? ctl.target : pc_ff;
      target_in     = csr_we ? csr_wdata : target_ff;
      count_tp_in   = count_tp_ff;
      count_fp_in   = count_fp_ff;
      count_tn_in   = count_tn_ff;
      count_fn_in   = count_fn_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quot_in       = quot_ff;
      iter_in       = iter_ff;
      dz_in         = dz_ff;
      ratio_in      = ratio_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;

      // saturating counter bump on each request
      if (req_acc) begin
         if (hit && is_target) begin
            if (count_tp_ff != '1) count_tp_in = count_tp_ff + 1'b1;
         end else if (hit) begin
            if (count_tn_ff != '1) count_tn_in = count_tn_ff + 1'b1;
         end else if (is_target) begin
            if (count_fn_ff != '1) count_fn_in = count_fn_ff + 1'b1;
         end else begin
            if (count_fp_ff != '1) count_fp_in = count_fp_ff + 1'b1;
         end
      end

      unique case (ctl.op)
         ovrcm_pkg::OP_LOAD: begin
            rem_in  = num_sel;
            den_in  = den_sel;
            dz_in   = (den_sel == '0);
            quot_in = '0;
            iter_in = ovrcm_pkg::ITER_BITS'(ovrcm_pkg::DIV_STEPS);
         end
         ovrcm_pkg::OP_DIV: begin
            rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
            quot_in = {quot_ff[RB-2:0], ge};
            iter_in = iter_ff - 1'b1;
         end
         ovrcm_pkg::OP_STORE: begin
            ratio_in[ctl.sel] = dz_ff ? dflt : quot_ff;
         end
         ovrcm_pkg::OP_EMIT: begin
            if (emit_go) begin
               rsp_tdata_in = {
                  {ovrcm_pkg::RSP_PAD_BITS{1'b0}},
                  ratio_ff[ovrcm_pkg::R_SPEC],
                  ratio_ff[ovrcm_pkg::R_ACC],
                  ratio_ff[ovrcm_pkg::R_PREC],
                  ratio_ff[ovrcm_pkg::R_FPR],
                  ratio_ff[ovrcm_pkg::R_TPR],
                  ovrcm_pkg::COUNT_FIELD_BITS'(count_fn_ff),
                  ovrcm_pkg::COUNT_FIELD_BITS'(count_tn_ff),
                  ovrcm_pkg::COUNT_FIELD_BITS'(count_fp_ff),
                  ovrcm_pkg::COUNT_FIELD_BITS'(count_tp_ff)
               };
               rsp_tvalid_in = 1'b1;
               count_tp_in   = '0;
               count_fp_in   = '0;
               count_tn_in   = '0;
               count_fn_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= ovrcm_pkg::A_IDLE;
         target_ff     <= CF'(1);
         count_tp_ff   <= '0;
         count_fp_ff   <= '0;
         count_tn_ff   <= '0;
         count_fn_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         target_ff     <= target_in;
         count_tp_ff   <= count_tp_in;
         count_fp_ff   <= count_fp_in;
         count_tn_ff   <= count_tn_in;
         count_fn_ff   <= count_fn_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quot_ff      <= quot_in;
      iter_ff      <= iter_in;
      dz_ff        <= dz_in;
      ratio_ff     <= ratio_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Checks
   `OVRCM_ASSERT_IMP(a_quot_in_range, clock, reset,
      (ctl.op == ovrcm_pkg::OP_STORE) && !dz_ff, quot_ff <= ovrcm_pkg::ONE_FIXED)
   `OVRCM_ASSERT_IMP(a_valid_from_emit, clock, reset,
      $rose(rsp_tvalid_ff), $past(ctl.op == ovrcm_pkg::OP_EMIT))
   `OVRCM_ASSERT_NXT(a_counts_hold_busy, clock, reset,
      (ctl.op != ovrcm_pkg::OP_WAIT_REQ) && (ctl.op != ovrcm_pkg::OP_EMIT),
      $stable(count_tp_ff) && $stable(count_fp_ff) &&
      $stable(count_tn_ff) && $stable(count_fn_ff))

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the one-versus-rest confusion metrics block.
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 110;
   localparam int GAP_MAX        = 17;

   typedef logic [ovrcm_pkg::CLASS_FIELD_BITS-1:0] class_type;
   typedef logic [ovrcm_pkg::COUNT_FIELD_BITS-1:0] count_type;
   typedef logic [ovrcm_pkg::RATIO_BITS-1:0]       fixed_type;

   // Response payload, highest field first so that true_pos lands in bit 0
   typedef struct packed {
      logic [ovrcm_pkg::RSP_PAD_BITS-1:0] pad;
      fixed_type                          spec_ratio;
      fixed_type                          acc_ratio;
      fixed_type                          prec_ratio;
      fixed_type                          fp_rate;
      fixed_type                          tp_rate;
      count_type                          false_neg;
      count_type                          true_neg;
      count_type                          false_pos;
      count_type                          true_pos;
   } metrics_type;

   logic                                clock;
   logic                                reset      = 1'b1;
   logic                                csr_we     = 1'b0;
   class_type                           csr_wdata  = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [ovrcm_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                                req_tlast  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [ovrcm_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   // Predictor state
   class_type   target_q = 8'd1;
   count_type   tally_tp = '0;
   count_type   tally_fp = '0;
   count_type   tally_tn = '0;
   count_type   tally_fn = '0;
   metrics_type metrics_due[$];

   int unsigned req_gap_max   = 0;
   int unsigned rsp_stall_max = 0;
   int unsigned mismatches    = 0;
   int unsigned samples_sent  = 0;
   int unsigned sets_checked  = 0;
   int unsigned targets_used  = 0;
   int unsigned quiet_cycles  = 0;

   one_vs_rest_confusion_metrics_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Q1.16 quotient, truncated; fixed value when the denominator is zero
   function automatic fixed_type q16_ratio(input longint unsigned num,
                                           input longint unsigned den,
                                           input fixed_type if_zero);
      if (den == 0) return if_zero;
      return fixed_type'((num << ovrcm_pkg::FRAC_BITS) / den);
   endfunction

   // Count one accepted sample; on the last of a set queue the expected metrics
   function automatic void score_sample(input class_type truth, input class_type guess,
                                        input bit last);
      metrics_type     m;
      longint unsigned tp, fp, tn, fn;
      if (truth == guess && truth == target_q) begin
         if (tally_tp != '1) tally_tp++;
      end else if (truth == guess) begin
         if (tally_tn != '1) tally_tn++;
      end else if (truth == target_q) begin
         if (tally_fn != '1) tally_fn++;
      end else begin
         if (tally_fp != '1) tally_fp++;
      end
      if (!last) return;
      tp = tally_tp;
      fp = tally_fp;
      tn = tally_tn;
      fn = tally_fn;
      m            = '0;
      m.true_pos   = tally_tp;
      m.false_pos  = tally_fp;
      m.true_neg   = tally_tn;
      m.false_neg  = tally_fn;
      m.tp_rate    = q16_ratio(tp, tp + fn, '0);
      m.fp_rate    = q16_ratio(fp, fp + tn, ovrcm_pkg::ONE_FIXED);
      m.prec_ratio = q16_ratio(tp, tp + fp, '0);
      m.acc_ratio  = q16_ratio(tp + tn, tp + fp + tn + fn, '0);
      m.spec_ratio = q16_ratio(tn, fp + tn, '0);
      metrics_due = {metrics_due, m};
      tally_tp = '0;
      tally_fp = '0;
      tally_tn = '0;
      tally_fn = '0;
   endfunction

   function automatic void check_field(input string what, input longint unsigned want,
                                       input longint unsigned got);
      if (want == got) return;
      if (mismatches < 10)
         $display("MISMATCH set %0d %s: expected %0d, got %0d", sets_checked, what, want, got);
      mismatches++;
   endfunction

   // Send one labelled sample; entered and left at a falling edge
   task automatic send_sample(input class_type truth, input class_type guess, input bit last);
      int unsigned gap;
      gap = $urandom_range(req_gap_max, 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {guess, truth};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      score_sample(truth, guess, last);
      @(negedge clock);
   endtask

   // Stop sending, wait for every queued result, then for the divider to settle
   task automatic drain_metrics;
      req_tvalid <= 1'b0;
      while (metrics_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_target(input class_type value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we   <= 1'b0;
      target_q  = value;
      targets_used++;
      @(negedge clock);
   endtask

   // Single-sample sets hit each zero denominator; mixed sets use extreme labels
   task automatic test_directed_cases;
      req_gap_max   = 3;
      rsp_stall_max = GAP_MAX;
      send_sample(8'd1, 8'd1, 1'b1);
      send_sample(8'd0, 8'd0, 1'b1);
      send_sample(8'd255, 8'd0, 1'b1);
      send_sample(8'd1, 8'd255, 1'b1);
      send_sample(8'd1, 8'd1, 1'b0);
      send_sample(8'd1, 8'd0, 1'b0);
      send_sample(8'd0, 8'd1, 1'b0);
      send_sample(8'd255, 8'd255, 1'b0);
      send_sample(8'd0, 8'd255, 1'b0);
      send_sample(8'd200, 8'd1, 1'b0);
      send_sample(8'd7, 8'd7, 1'b1);
      drain_metrics();
      write_target(8'd255);
      send_sample(8'd255, 8'd255, 1'b0);
      send_sample(8'd255, 8'd0, 1'b0);
      send_sample(8'd0, 8'd255, 1'b0);
      send_sample(8'd0, 8'd0, 1'b1);
      drain_metrics();
      write_target(8'd0);
      send_sample(8'd0, 8'd0, 1'b0);
      send_sample(8'd0, 8'd0, 1'b0);
      send_sample(8'd255, 8'd0, 1'b0);
      send_sample(8'd170, 8'd85, 1'b1);
      drain_metrics();
   endtask

   // Random sets under several target settings, with random pacing on both sides
   task automatic test_random_sets;
      class_type   phase_target[6];
      class_type   truth, guess;
      int unsigned phase, set_len, k, items;
      phase_target = '{8'd0, 8'd255, class_type'($urandom), 8'd1, class_type'($urandom),
                       class_type'($urandom)};
      for (phase = 0; phase < 6; phase++) begin
         write_target(phase_target[phase]);
         items = 0;
         while (items < 95) begin
            req_gap_max   = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
            rsp_stall_max = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
            set_len = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 25)
                                                  : $urandom_range(24, 1);
            for (k = 1; k <= set_len; k++) begin
               truth = $urandom_range(1, 0) ? target_q : class_type'($urandom);
               case ($urandom_range(3, 0))
                  0, 1:    guess = truth;
                  2:       guess = target_q;
                  default: guess = class_type'($urandom);
               endcase
               send_sample(truth, guess, k == set_len);
            end
            items += set_len;
         end
         drain_metrics();
      end
   endtask

   // Response side: random back-pressure, then compare with the oldest expectation
   initial begin
      int unsigned stall;
      metrics_type got, want;
      forever begin
         stall = $urandom_range(rsp_stall_max, 0);
         rsp_tready <= (stall == 0);
         do @(posedge clock); while (!rsp_tvalid);
         if (stall != 0) begin
            repeat (stall) @(negedge clock);
            rsp_tready <= 1'b1;
            do @(posedge clock); while (!rsp_tvalid);
         end
         got = metrics_type'(rsp_tdata);
         if (metrics_due.size() == 0) begin
            if (mismatches < 10) $display("MISMATCH: result with no set pending");
            mismatches++;
         end else begin
            want = metrics_due.pop_front();
            check_field("true_pos", want.true_pos, got.true_pos);
            check_field("false_pos", want.false_pos, got.false_pos);
            check_field("true_neg", want.true_neg, got.true_neg);
            check_field("false_neg", want.false_neg, got.false_neg);
            check_field("tp_rate", want.tp_rate, got.tp_rate);
            check_field("fp_rate", want.fp_rate, got.fp_rate);
            check_field("precision_ratio", want.prec_ratio, got.prec_ratio);
            check_field("accuracy_ratio", want.acc_ratio, got.acc_ratio);
            check_field("specificity_ratio", want.spec_ratio, got.spec_ratio);
         end
         sets_checked++;
         @(negedge clock);
      end
   end

   // Watchdog: too long without a request or a result moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d quiet cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_cases();
      test_random_sets();
      drain_metrics();
      $display("Covered %0d samples in %0d checked sets under %0d target settings,",
               samples_sent, sets_checked, targets_used + 1);
      $display("including every zero-denominator ratio and random back-pressure.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d field mismatches", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
